// ===== design/dkt_pkg.sv =====
`timescale 1ns / 1ps

package dkt_pkg;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned SADDR_W  = 8;
  localparam int unsigned SKEY_W   = 64;
  localparam int unsigned NONCE_W  = 16;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD       = 3'd0,
    FN_REMOVE    = 3'd1,
    FN_FIND_KEY  = 3'd2,
    FN_FIND_ADDR = 3'd3,
    FN_READ_SLOT = 3'd4
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2,
    ST_RANGE   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SLOT_DATA,
    S_MOVE_RD,
    S_MOVE_WR,
    S_DONE
  } state_e;

  // one table record as held in the record memory
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [SADDR_W-1:0] addr;
    logic [SKEY_W-1:0]  skey_high;
    logic [SKEY_W-1:0]  skey_low;
    logic [NONCE_W-1:0] nonce;
    logic [TIME_W-1:0]  seen;
  } rec_t;

  typedef struct packed {
    status_e             status;
    logic [INDEX_W-1:0]  entry_index;
    logic [COUNT_W-1:0]  entry_count;
    rec_t                rec;
  } res_t;

endpackage

// ===== design/dkt_if.sv =====
`timescale 1ns / 1ps

interface dkt_in_if;
  import dkt_pkg::*;

  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [KEY_W-1:0]   device_key;
  logic [SADDR_W-1:0] short_address;
  logic [SKEY_W-1:0]  session_key_high;
  logic [SKEY_W-1:0]  session_key_low;
  logic [NONCE_W-1:0] join_nonce;
  logic [SLOT_W-1:0]  slot_index;
  logic [TIME_W-1:0]  time_now_ms;

  modport source (
    output valid, func, device_key, short_address, session_key_high,
           session_key_low, join_nonce, slot_index, time_now_ms,
    input  ready
  );

  modport sink (
    input  valid, func, device_key, short_address, session_key_high,
           session_key_low, join_nonce, slot_index, time_now_ms,
    output ready
  );
endinterface

interface dkt_out_if;
  import dkt_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  entry_index;
  logic [COUNT_W-1:0]  entry_count;
  logic [KEY_W-1:0]    found_key;
  logic [SADDR_W-1:0]  found_address;
  logic [SKEY_W-1:0]   found_key_high;
  logic [SKEY_W-1:0]   found_key_low;
  logic [NONCE_W-1:0]  found_nonce;
  logic [TIME_W-1:0]   found_last_seen;

  modport source (
    output valid, status, entry_index, entry_count, found_key, found_address,
           found_key_high, found_key_low, found_nonce, found_last_seen,
    input  ready
  );

  modport sink (
    input  valid, status, entry_index, entry_count, found_key, found_address,
           found_key_high, found_key_low, found_nonce, found_last_seen,
    output ready
  );
endinterface

// ===== design/device_key_table_unit.sv =====
`timescale 1ns / 1ps

// Device key table: up to TABLE_DEPTH records keyed by a 64-bit device id, held in a
// single-port-write, single-port-read record memory with registered read. Add, remove,
// find by key and find by address walk the valid records through the one read port,
// one record per cycle, with a single shared comparator checking the previous read, until
// a match or the last record; a remove that has to move the last record into the hole
// adds a read and a write of that record. Read at index reads the slot and then loads
// its result, and a rejected index or unused function code goes straight to the result.
// The input is not ready while an operation is in flight and opens again in the cycle
// after the result is loaded;
// the finished result sits in an output register, so the next transaction can be
// accepted while the previous result waits to be taken.
module device_key_table_unit #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dkt_in_if.sink     req_i,
  dkt_out_if.source  rsp_o
);
  import dkt_pkg::*;

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  cmp_idx_q, cmp_idx_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [CNT_W-1:0]  hit_q, hit_d;
  logic [FUNC_W-1:0] func_q, func_d;
  rec_t              op_rec_q, op_rec_d;
  res_t              res_q, res_d;
  res_t              out_q;
  logic              out_vld_q;
  logic              out_load;

  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  rec_t              rd_data;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  rec_t              wr_data;

  logic                    accept;
  rec_t                    in_rec;
  logic [CNT_W+SLOT_W-1:0] slot_ext;
  logic [CNT_W+SLOT_W-1:0] cnt_ext;
  logic                    slot_ok;
  logic [CNT_W-1:0]        last_idx;
  logic                    issue;
  logic                    match;
  logic                    scan_miss;

  function automatic logic [INDEX_W-1:0] to_index(input logic [CNT_W-1:0] v);
    logic [CNT_W+INDEX_W-1:0] w;
    w = {{INDEX_W{1'b0}}, v};
    return w[INDEX_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] to_count(input logic [CNT_W-1:0] v);
    logic [CNT_W+COUNT_W-1:0] w;
    w = {{COUNT_W{1'b0}}, v};
    return w[COUNT_W-1:0];
  endfunction

  function automatic res_t empty_res(input status_e st, input logic [CNT_W-1:0] cnt);
    res_t r;
    r             = '0;
    r.status      = st;
    r.entry_count = to_count(cnt);
    return r;
  endfunction

  function automatic res_t entry_res(input rec_t rec, input logic [CNT_W-1:0] pos,
                                     input logic [CNT_W-1:0] cnt);
    res_t r;
    r.status      = ST_OK;
    r.entry_index = to_index(pos);
    r.entry_count = to_count(cnt);
    r.rec         = rec;
    return r;
  endfunction

  dkt_ram #(
    .WIDTH ($bits(rec_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_rec_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  always_comb begin
    in_rec.key       = req_i.device_key;
    in_rec.addr      = req_i.short_address;
    in_rec.skey_high = req_i.session_key_high;
    in_rec.skey_low  = req_i.session_key_low;
    in_rec.nonce     = req_i.join_nonce;
    in_rec.seen      = req_i.time_now_ms;
  end

  assign slot_ext = {{CNT_W{1'b0}}, req_i.slot_index};
  assign cnt_ext  = {{SLOT_W{1'b0}}, count_q};
  assign slot_ok  = slot_ext < cnt_ext;
  assign last_idx = count_q - CNT_W'(1);

  // shared comparator: the record read last cycle against the searched key or address
  assign match = cmp_vld_q &&
                 ((func_q == FN_FIND_ADDR) ? (rd_data.addr == op_rec_q.addr)
                                           : (rd_data.key == op_rec_q.key));
  assign scan_miss = (count_q == '0) ||
                     (cmp_vld_q && !match && (cmp_idx_q == last_idx));
  assign issue = (idx_q < count_q);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    cmp_idx_d = cmp_idx_q;
    cmp_vld_d = cmp_vld_q;
    hit_d     = hit_q;
    func_d    = func_q;
    op_rec_d  = op_rec_q;
    res_d     = res_q;
    out_load  = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = idx_q[IDX_W-1:0];
    wr_en     = 1'b0;
    wr_addr   = cmp_idx_q[IDX_W-1:0];
    wr_data   = op_rec_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          func_d   = req_i.func;
          op_rec_d = in_rec;
          case (req_i.func)
            FN_ADD, FN_REMOVE, FN_FIND_KEY, FN_FIND_ADDR: begin
              idx_d     = '0;
              cmp_vld_d = 1'b0;
              state_d   = S_SCAN;
            end
            FN_READ_SLOT: begin
              if (slot_ok) begin
                rd_en   = 1'b1;
                rd_addr = slot_ext[IDX_W-1:0];
                hit_d   = slot_ext[CNT_W-1:0];
                state_d = S_SLOT_DATA;
              end else begin
                res_d   = empty_res(ST_RANGE, count_q);
                state_d = S_DONE;
              end
            end
            default: begin
              res_d   = empty_res(ST_MISSING, count_q);
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // read one record ahead while the previous one is compared
        rd_en     = issue;
        cmp_vld_d = issue;
        cmp_idx_d = idx_q;
        if (issue) begin
          idx_d = idx_q + CNT_W'(1);
        end
        if (match) begin
          state_d = S_DONE;
          case (func_q)
            FN_ADD: begin
              wr_en   = 1'b1;
              wr_addr = cmp_idx_q[IDX_W-1:0];
              wr_data = op_rec_q;
              res_d   = entry_res(op_rec_q, cmp_idx_q, count_q);
            end
            FN_REMOVE: begin
              res_d   = entry_res(rd_data, cmp_idx_q, last_idx);
              count_d = last_idx;
              hit_d   = cmp_idx_q;
              if (cmp_idx_q != last_idx) begin
                state_d = S_MOVE_RD;
              end
            end
            default: begin
              res_d = entry_res(rd_data, cmp_idx_q, count_q);
            end
          endcase
        end else if (scan_miss) begin
          state_d = S_DONE;
          if (func_q == FN_ADD) begin
            if (count_q == DEPTH_C) begin
              res_d = empty_res(ST_FULL, count_q);
            end else begin
              wr_en   = 1'b1;
              wr_addr = count_q[IDX_W-1:0];
              wr_data = op_rec_q;
              count_d = count_q + CNT_W'(1);
              res_d   = entry_res(op_rec_q, count_q, count_q + CNT_W'(1));
            end
          end else begin
            res_d = empty_res(ST_MISSING, count_q);
          end
        end
      end

      S_SLOT_DATA: begin
        res_d   = entry_res(rd_data, hit_q, count_q);
        state_d = S_DONE;
      end

      // count already dropped, so it now points at the last record
      S_MOVE_RD: begin
        rd_en   = 1'b1;
        rd_addr = count_q[IDX_W-1:0];
        state_d = S_MOVE_WR;
      end

      S_MOVE_WR: begin
        wr_en   = 1'b1;
        wr_addr = hit_q[IDX_W-1:0];
        wr_data = rd_data;
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      idx_q     <= '0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      cmp_vld_q <= cmp_vld_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    hit_q     <= hit_d;
    func_q    <= func_d;
    op_rec_q  <= op_rec_d;
    res_q     <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign rsp_o.valid           = out_vld_q;
  assign rsp_o.status          = out_q.status;
  assign rsp_o.entry_index     = out_q.entry_index;
  assign rsp_o.entry_count     = out_q.entry_count;
  assign rsp_o.found_key       = out_q.rec.key;
  assign rsp_o.found_address   = out_q.rec.addr;
  assign rsp_o.found_key_high  = out_q.rec.skey_high;
  assign rsp_o.found_key_low   = out_q.rec.skey_low;
  assign rsp_o.found_nonce     = out_q.rec.nonce;
  assign rsp_o.found_last_seen = out_q.rec.seen;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("record count above table depth");

  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == S_SCAN || state_q == S_MOVE_WR))
    else $error("record memory written outside scan or move");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      ($past(state_q) == S_SCAN &&
       (count_q == $past(count_q) + CNT_W'(1) || count_q == $past(count_q) - CNT_W'(1))))
    else $error("record count changed by more than one or outside scan");

endmodule

// ===== design/dkt_ram.sv =====
`timescale 1ns / 1ps

module dkt_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import dkt_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned KEY_POOL_SIZE = 24;
  localparam int unsigned ADDR_POOL_SIZE = 6;
  localparam logic [FUNC_W-1:0] FN_SPARE_FIRST = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SPARE_LAST = 3'd7;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [KEY_W-1:0]   device_key;
    logic [SADDR_W-1:0] short_address;
    logic [SKEY_W-1:0]  session_key_high;
    logic [SKEY_W-1:0]  session_key_low;
    logic [NONCE_W-1:0] join_nonce;
    logic [SLOT_W-1:0]  slot_index;
    logic [TIME_W-1:0]  time_now_ms;
  } table_op_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  dkt_in_if  req_if ();
  dkt_out_if rsp_if ();

  device_key_table_unit #(
    .TABLE_DEPTH(DEPTH)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // shadow copy of the device table
  rec_t        shadow_rec [DEPTH];
  int unsigned shadow_count;
  res_t        awaited_answers [$];

  logic [KEY_W-1:0]   key_pool  [KEY_POOL_SIZE];
  logic [SADDR_W-1:0] addr_pool [ADDR_POOL_SIZE];

  int unsigned error_count = 0;
  int unsigned answers_seen = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_request;
  int unsigned hold_taken = 0;
  int unsigned stall_left;
  bit          no_idle;
  res_t        head_answer;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [SADDR_W-1:0] rand_addr();
    return SADDR_W'($urandom);
  endfunction

  function automatic logic [NONCE_W-1:0] rand_nonce();
    return NONCE_W'($urandom);
  endfunction

  function automatic logic [SLOT_W-1:0] rand_slot();
    return SLOT_W'($urandom);
  endfunction

  function automatic int find_shadow_key(input logic [KEY_W-1:0] key);
    for (int i = 0; i < int'(shadow_count); i++) begin
      if (shadow_rec[i].key == key) return i;
    end
    return -1;
  endfunction

  function automatic int find_shadow_addr(input logic [SADDR_W-1:0] addr);
    for (int i = 0; i < int'(shadow_count); i++) begin
      if (shadow_rec[i].addr == addr) return i;
    end
    return -1;
  endfunction

  function automatic res_t record_answer(input int pos);
    res_t r;
    r = '0;
    r.status = ST_OK;
    r.entry_index = pos[INDEX_W-1:0];
    r.rec = shadow_rec[pos];
    return r;
  endfunction

  // applies one operation to the shadow table and returns the answer it must give
  function automatic res_t update_table_shadow(input table_op_t op);
    res_t r;
    int   pos;
    int   last;
    r = '0;
    r.status = ST_MISSING;
    case (op.func)
      FN_ADD: begin
        pos = find_shadow_key(op.device_key);
        if (pos < 0 && shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (pos < 0) begin
            pos = shadow_count;
            shadow_count++;
            shadow_rec[pos].key = op.device_key;
          end
          shadow_rec[pos].addr = op.short_address;
          shadow_rec[pos].skey_high = op.session_key_high;
          shadow_rec[pos].skey_low = op.session_key_low;
          shadow_rec[pos].nonce = op.join_nonce;
          shadow_rec[pos].seen = op.time_now_ms;
          r = record_answer(pos);
        end
      end
      FN_REMOVE: begin
        pos = find_shadow_key(op.device_key);
        if (pos >= 0) begin
          r = record_answer(pos);
          last = shadow_count - 1;
          // the last record fills the hole
          if (pos != last) shadow_rec[pos] = shadow_rec[last];
          shadow_count = last;
        end
      end
      FN_FIND_KEY: begin
        pos = find_shadow_key(op.device_key);
        if (pos >= 0) r = record_answer(pos);
      end
      FN_FIND_ADDR: begin
        pos = find_shadow_addr(op.short_address);
        if (pos >= 0) r = record_answer(pos);
      end
      FN_READ_SLOT: begin
        if (op.slot_index >= shadow_count) r.status = ST_RANGE;
        else r = record_answer(op.slot_index);
      end
      default: r.status = ST_MISSING;
    endcase
    r.entry_count = shadow_count[COUNT_W-1:0];
    return r;
  endfunction

  function automatic table_op_t make_add(input logic [KEY_W-1:0] key,
                                         input logic [SADDR_W-1:0] addr,
                                         input logic [SKEY_W-1:0] hi,
                                         input logic [SKEY_W-1:0] lo,
                                         input logic [NONCE_W-1:0] nonce,
                                         input logic [TIME_W-1:0] now);
    table_op_t op;
    op = '0;
    op.func = FN_ADD;
    op.device_key = key;
    op.short_address = addr;
    op.session_key_high = hi;
    op.session_key_low = lo;
    op.join_nonce = nonce;
    op.time_now_ms = now;
    return op;
  endfunction

  // lookups carry random data in the fields they do not use
  function automatic table_op_t make_lookup(input logic [FUNC_W-1:0] func,
                                            input logic [KEY_W-1:0] key,
                                            input logic [SADDR_W-1:0] addr,
                                            input logic [SLOT_W-1:0] slot);
    table_op_t op;
    op = make_add(key, addr, rand64(), rand64(), rand_nonce(), $urandom);
    op.func = func;
    op.slot_index = slot;
    return op;
  endfunction

  function automatic table_op_t make_random_op(input int unsigned add_pct,
                                               input int unsigned remove_pct);
    table_op_t            op;
    int unsigned          r;
    logic [FUNC_W-1:0]    func;
    logic [KEY_W-1:0]     key;
    logic [SADDR_W-1:0]   addr;
    r = $urandom_range(0, 99);
    if (r < add_pct) func = FN_ADD;
    else if (r < add_pct + remove_pct) func = FN_REMOVE;
    else if (r < add_pct + remove_pct + 14) func = FN_FIND_KEY;
    else if (r < add_pct + remove_pct + 28) func = FN_FIND_ADDR;
    else if (r < 96) func = FN_READ_SLOT;
    else func = FUNC_W'($urandom_range(FN_SPARE_FIRST, FN_SPARE_LAST));
    key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)]
                                        : rand64();
    addr = ($urandom_range(0, 99) < 70) ? addr_pool[$urandom_range(0, ADDR_POOL_SIZE - 1)]
                                         : rand_addr();
    op = make_lookup(func, key, addr, rand_slot());
    return op;
  endfunction

  task automatic send_op(input table_op_t op);
    int unsigned gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.func <= op.func;
    req_if.device_key <= op.device_key;
    req_if.short_address <= op.short_address;
    req_if.session_key_high <= op.session_key_high;
    req_if.session_key_low <= op.session_key_low;
    req_if.join_nonce <= op.join_nonce;
    req_if.slot_index <= op.slot_index;
    req_if.time_now_ms <= op.time_now_ms;
    req_if.valid <= 1'b1;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    awaited_answers.push_back(update_table_shadow(op));
  endtask

  task automatic wait_all_answered();
    req_if.valid <= 1'b0;
    while (awaited_answers.size() != 0) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    if (error_count <= 100)
      $display("result %0d: %s is %0h, expected %0h", answers_seen, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // response side: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_left = 0;
    end else if (hold_request != hold_taken) begin
      stall_left = hold_request;
      hold_taken = hold_request;
      rsp_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_if.ready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 99) < 25) begin
      stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                 : $urandom_range(8, 40);
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      answers_seen++;
      if (awaited_answers.size() == 0) begin
        report_mismatch("unexpected transaction", 64'd0, 64'd0);
      end else begin
        head_answer = awaited_answers.pop_front();
        check_field("status", 64'(rsp_if.status), 64'(head_answer.status));
        check_field("entry_index", 64'(rsp_if.entry_index), 64'(head_answer.entry_index));
        check_field("entry_count", 64'(rsp_if.entry_count), 64'(head_answer.entry_count));
        check_field("found_key", rsp_if.found_key, head_answer.rec.key);
        check_field("found_address", 64'(rsp_if.found_address),
                    64'(head_answer.rec.addr));
        check_field("found_key_high", rsp_if.found_key_high, head_answer.rec.skey_high);
        check_field("found_key_low", rsp_if.found_key_low, head_answer.rec.skey_low);
        check_field("found_nonce", 64'(rsp_if.found_nonce), 64'(head_answer.rec.nonce));
        check_field("found_last_seen", 64'(rsp_if.found_last_seen),
                    64'(head_answer.rec.seen));
      end
    end
  end

  // empty table, unused codes, extremes, update, duplicate address, removes
  task automatic test_directed_edges();
    logic [KEY_W-1:0] second_key;
    second_key = 64'h0123_4567_89ab_cdef;
    send_op(make_lookup(FN_READ_SLOT, '0, '0, '0));
    send_op(make_lookup(FN_FIND_KEY, '0, '0, '0));
    send_op(make_lookup(FN_FIND_ADDR, '1, '0, '1));
    send_op(make_lookup(FN_REMOVE, '1, '1, '0));
    for (int f = FN_SPARE_FIRST; f <= FN_SPARE_LAST; f++)
      send_op(make_lookup(f[FUNC_W-1:0], rand64(), rand_addr(), rand_slot()));
    send_op(make_add('1, '1, '1, '1, '1, '1));
    send_op(make_add('0, '0, '0, '0, '0, '0));
    send_op(make_add(second_key, '1, 64'haaaa_5555_aaaa_5555, 64'h5555_aaaa_5555_aaaa,
                     16'h8001, 32'h8000_0001));
    send_op(make_lookup(FN_FIND_ADDR, rand64(), '1, rand_slot()));
    send_op(make_add('0, 8'h5a, rand64(), rand64(), rand_nonce(), $urandom));
    send_op(make_lookup(FN_FIND_KEY, '0, rand_addr(), rand_slot()));
    send_op(make_lookup(FN_READ_SLOT, rand64(), rand_addr(), 4'd2));
    send_op(make_lookup(FN_READ_SLOT, rand64(), rand_addr(), 4'd3));
    send_op(make_lookup(FN_READ_SLOT, rand64(), rand_addr(), '1));
    // removing the first record moves the last one into its place
    send_op(make_lookup(FN_REMOVE, '1, rand_addr(), rand_slot()));
    send_op(make_lookup(FN_FIND_ADDR, rand64(), '1, rand_slot()));
    send_op(make_lookup(FN_REMOVE, '0, rand_addr(), rand_slot()));
    send_op(make_lookup(FN_REMOVE, '0, rand_addr(), rand_slot()));
    send_op(make_lookup(FN_READ_SLOT, rand64(), rand_addr(), '0));
    send_op(make_lookup(FN_REMOVE, second_key, rand_addr(), rand_slot()));
  endtask

  task automatic test_table_full();
    logic [KEY_W-1:0] keys [DEPTH];
    for (int i = 0; i < DEPTH; i++) begin
      keys[i] = (rand64() << 8) | KEY_W'(i[7:0]);
      send_op(make_add(keys[i], rand_addr(), rand64(), rand64(), rand_nonce(), $urandom));
    end
    send_op(make_add(~keys[0], rand_addr(), rand64(), rand64(), rand_nonce(), $urandom));
    send_op(make_add(keys[DEPTH-1], rand_addr(), rand64(), rand64(), rand_nonce(),
                     $urandom));
    send_op(make_lookup(FN_READ_SLOT, rand64(), rand_addr(), '1));
    send_op(make_lookup(FN_FIND_KEY, keys[DEPTH-1], rand_addr(), rand_slot()));
    send_op(make_lookup(FN_REMOVE, keys[0], rand_addr(), rand_slot()));
    send_op(make_add(~keys[0], rand_addr(), rand64(), rand64(), rand_nonce(), $urandom));
    for (int i = 1; i < DEPTH; i++)
      send_op(make_lookup(FN_REMOVE, keys[i], rand_addr(), rand_slot()));
    send_op(make_lookup(FN_REMOVE, ~keys[0], rand_addr(), rand_slot()));
  endtask

  // alternate growing and shrinking phases so the count sweeps its range
  task automatic test_random_mix();
    for (int phase = 0; phase < 6; phase++) begin
      for (int i = 0; i < 210; i++) begin
        if (phase % 2 == 0) send_op(make_random_op(45, 12));
        else send_op(make_random_op(15, 42));
      end
    end
  endtask

  task automatic test_output_backpressure();
    hold_request = 400;
    for (int i = 0; i < 40; i++) send_op(make_random_op(35, 20));
  endtask

  task automatic test_drain_pauses();
    for (int round = 0; round < 5; round++) begin
      for (int i = 0; i < 20; i++) send_op(make_random_op(35, 20));
      wait_all_answered();
      @(posedge clk_i);
    end
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    for (int i = 0; i < 200; i++) send_op(make_random_op(30, 25));
    no_idle = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    req_if.valid <= 1'b0;
    req_if.func <= '0;
    req_if.device_key <= '0;
    req_if.short_address <= '0;
    req_if.session_key_high <= '0;
    req_if.session_key_low <= '0;
    req_if.join_nonce <= '0;
    req_if.slot_index <= '0;
    req_if.time_now_ms <= '0;
    shadow_count = 0;
    hold_request = 0;
    no_idle = 1'b0;
    for (int i = 0; i < KEY_POOL_SIZE; i++) key_pool[i] = rand64();
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 0; i < ADDR_POOL_SIZE; i++) addr_pool[i] = rand_addr();
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_edges();
    test_table_full();
    test_random_mix();
    test_output_backpressure();
    test_drain_pauses();
    test_back_to_back();

    wait_all_answered();
    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
